[rtl/kcled_pkg.sv]
package kcled_pkg;

  localparam int MSG_SLOTS = 4;
  localparam int CNT_W     = $clog2(MSG_SLOTS + 1);

  localparam int KEY_W     = 8;
  localparam int MS_W      = 16;
  localparam int TOG_W     = 4;
  localparam int STAGE_W   = 3;
  localparam int SCNT_W    = 3;
  localparam int SLOT_W    = 2;
  localparam int LED_W     = 3;
  localparam int DM_W      = 2;
  localparam int CFG_IDX_W = 2;

  // entry sequence states
  localparam logic [STAGE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STAGE_W-1:0] ST_DIG1   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DIG2   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_LETTER = 3'd3;
  localparam logic [STAGE_W-1:0] ST_STAR   = 3'd4;

  // display modes
  localparam logic [DM_W-1:0] DM_NONE  = 2'd0;
  localparam logic [DM_W-1:0] DM_SHORT = 2'd1;
  localparam logic [DM_W-1:0] DM_BLINK = 2'd2;

  // LED bit patterns
  localparam logic [LED_W-1:0] LED_NONE = 3'b000;
  localparam logic [LED_W-1:0] LED_ACK  = 3'b001;
  localparam logic [LED_W-1:0] LED_ERR  = 3'b010;
  localparam logic [LED_W-1:0] LED_FULL = 3'b100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SHOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOG  = 2'd2;

  localparam logic [MS_W-1:0]  RST_SHORT_SHOW = 16'd300;
  localparam logic [MS_W-1:0]  RST_BLINK_HALF = 16'd100;
  localparam logic [TOG_W-1:0] RST_BLINK_TOG  = 4'd10;

  // ASCII codes
  localparam logic [KEY_W-1:0] CH_HASH = 8'h23;
  localparam logic [KEY_W-1:0] CH_STAR = 8'h2A;
  localparam logic [KEY_W-1:0] CH_0    = 8'h30;
  localparam logic [KEY_W-1:0] CH_9    = 8'h39;
  localparam logic [KEY_W-1:0] CH_A    = 8'h41;
  localparam logic [KEY_W-1:0] CH_D    = 8'h44;

  typedef struct packed {
    logic             op;
    logic             key_down;
    logic [KEY_W-1:0] key_code;
  } item_t;

  typedef struct packed {
    logic             req;
    logic [DM_W-1:0]  mode;
    logic [LED_W-1:0] leds;
  } show_t;

  typedef struct packed {
    logic [MS_W-1:0]  short_show_ms;
    logic [MS_W-1:0]  blink_half_ms;
    logic [TOG_W-1:0] blink_toggles;
  } cfg_t;

  typedef struct packed {
    logic [STAGE_W-1:0] entry_stage;
    logic [SCNT_W-1:0]  stored_count;
    logic               msg_done;
    logic [SLOT_W-1:0]  msg_slot;
    logic [KEY_W-1:0]   msg_first_digit;
    logic [KEY_W-1:0]   msg_second_digit;
    logic [KEY_W-1:0]   msg_letter;
  } msg_t;

endpackage

[rtl/kcled_ifs.sv]
interface kcled_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic                       key_down;
  logic [kcled_pkg::KEY_W-1:0] key_code;

  modport source (output valid, op, key_down, key_code, input ready);
  modport sink   (input valid, op, key_down, key_code, output ready);
endinterface

interface kcled_out_if;
  logic                          valid;
  logic                          ready;
  logic                          led_ack;
  logic                          led_error;
  logic                          led_full;
  logic [kcled_pkg::STAGE_W-1:0] entry_stage;
  logic [kcled_pkg::SCNT_W-1:0]  stored_count;
  logic                          msg_done;
  logic [kcled_pkg::SLOT_W-1:0]  msg_slot;
  logic [kcled_pkg::KEY_W-1:0]   msg_first_digit;
  logic [kcled_pkg::KEY_W-1:0]   msg_second_digit;
  logic [kcled_pkg::KEY_W-1:0]   msg_letter;

  modport source (output valid, led_ack, led_error, led_full, entry_stage, stored_count,
                  msg_done, msg_slot, msg_first_digit, msg_second_digit, msg_letter,
                  input ready);
  modport sink   (input valid, led_ack, led_error, led_full, entry_stage, stored_count,
                  msg_done, msg_slot, msg_first_digit, msg_second_digit, msg_letter,
                  output ready);
endinterface

interface kcled_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kcled_pkg::CFG_IDX_W-1:0] index;
  logic [kcled_pkg::MS_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/kcled_cfg.sv]
module kcled_cfg (
  input  logic            clk,
  input  logic            rst_n,
  kcled_cfg_if.sink       cfg_ch,
  output kcled_pkg::cfg_t cfg
);
  import kcled_pkg::*;

  logic [MS_W-1:0]  short_show_r;
  logic [MS_W-1:0]  blink_half_r;
  logic [TOG_W-1:0] blink_tog_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_show_r <= RST_SHORT_SHOW;
      blink_half_r <= RST_BLINK_HALF;
      blink_tog_r  <= RST_BLINK_TOG;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SHORT_SHOW: short_show_r <= cfg_ch.data;
        CFG_BLINK_HALF: blink_half_r <= cfg_ch.data;
        CFG_BLINK_TOG:  blink_tog_r  <= cfg_ch.data[TOG_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg.short_show_ms = short_show_r;
  assign cfg.blink_half_ms = blink_half_r;
  assign cfg.blink_toggles = blink_tog_r;
endmodule

[rtl/kcled_entry.sv]
module kcled_entry (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  kcled_pkg::item_t item,
  output kcled_pkg::show_t show,
  output kcled_pkg::msg_t  msg
);
  import kcled_pkg::*;

  logic [STAGE_W-1:0] state_r, state_nxt;
  logic [KEY_W-1:0]   dig1_r, dig1_nxt;
  logic [KEY_W-1:0]   dig2_r, dig2_nxt;
  logic [KEY_W-1:0]   letter_r, letter_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pressed_r, pressed_nxt;

  logic                press;
  logic                is_digit;
  logic                is_letter;
  logic                done;
  logic [CNT_W+2:0]    count_ext;
  logic [CNT_W+1:0]    slot_ext;

  assign press     = !item.op && item.key_down && !pressed_r;
  assign is_digit  = (item.key_code >= CH_0) && (item.key_code <= CH_9);
  assign is_letter = (item.key_code >= CH_A) && (item.key_code <= CH_D);

  always_comb begin
    state_nxt   = state_r;
    dig1_nxt    = dig1_r;
    dig2_nxt    = dig2_r;
    letter_nxt  = letter_r;
    count_nxt   = count_r;
    pressed_nxt = pressed_r;
    done        = 1'b0;
    show        = '{req: 1'b0, mode: DM_NONE, leds: LED_NONE};

    if (!item.op) pressed_nxt = item.key_down;

    if (press) begin
      // any wrong key: error and back to idle (overridden below on a match)
      show      = '{req: 1'b1, mode: DM_SHORT, leds: LED_ERR};
      state_nxt = ST_IDLE;
      unique case (state_r)
        ST_IDLE: begin
          if (item.key_code == CH_HASH) begin
            state_nxt = ST_DIG1;
            show.leds = LED_ACK;
          end
        end
        ST_DIG1: begin
          if (is_digit) begin
            dig1_nxt  = item.key_code;
            state_nxt = ST_DIG2;
            show.leds = LED_ACK;
          end
        end
        ST_DIG2: begin
          if (is_digit) begin
            dig2_nxt  = item.key_code;
            state_nxt = ST_LETTER;
            show.leds = LED_ACK;
          end
        end
        ST_LETTER: begin
          if (is_letter) begin
            letter_nxt = item.key_code;
            state_nxt  = ST_STAR;
            show.leds  = LED_ACK;
          end
        end
        ST_STAR: begin
          if (item.key_code == CH_STAR) begin
            if (count_r < CNT_W'(MSG_SLOTS)) begin
              done      = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              show      = '{req: 1'b1, mode: DM_BLINK, leds: LED_NONE};
            end else begin
              show.leds = LED_FULL;
            end
          end
        end
        default: begin
          // unreachable codes fall back to idle quietly
          show.req = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dig1_r    <= '0;
      dig2_r    <= '0;
      letter_r  <= '0;
      count_r   <= '0;
      pressed_r <= 1'b0;
    end else if (en) begin
      state_r   <= state_nxt;
      dig1_r    <= dig1_nxt;
      dig2_r    <= dig2_nxt;
      letter_r  <= letter_nxt;
      count_r   <= count_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  assign count_ext = {3'b000, count_nxt};
  assign slot_ext  = {2'b00, count_r};

  assign msg.entry_stage      = state_nxt;
  assign msg.stored_count     = count_ext[SCNT_W-1:0];
  assign msg.msg_done         = done;
  assign msg.msg_slot         = done ? slot_ext[SLOT_W-1:0] : '0;
  assign msg.msg_first_digit  = done ? dig1_r : '0;
  assign msg.msg_second_digit = done ? dig2_r : '0;
  assign msg.msg_letter       = done ? letter_r : '0;
endmodule

[rtl/kcled_disp.sv]
module kcled_disp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        tick,
  input  kcled_pkg::show_t            show,
  input  kcled_pkg::cfg_t             cfg,
  output logic [kcled_pkg::LED_W-1:0] leds
);
  import kcled_pkg::*;

  logic [DM_W-1:0]  mode_r, mode_nxt;
  logic [MS_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TOG_W-1:0] blinks_r, blinks_nxt;
  logic             phase_r, phase_nxt;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [MS_W-1:0]  el_inc;

  // saturating millisecond count
  assign el_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + MS_W'(1);

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    blinks_nxt  = blinks_r;
    phase_nxt   = phase_r;
    led_nxt     = led_r;

    if (show.req) begin
      mode_nxt    = show.mode;
      led_nxt     = show.leds;
      elapsed_nxt = '0;
      phase_nxt   = 1'b0;
      blinks_nxt  = (show.mode == DM_BLINK) ? cfg.blink_toggles : '0;
    end else if (tick) begin
      unique case (mode_r)
        DM_SHORT: begin
          elapsed_nxt = el_inc;
          if (el_inc >= cfg.short_show_ms) begin
            led_nxt  = LED_NONE;
            mode_nxt = DM_NONE;
          end
        end
        DM_BLINK: begin
          elapsed_nxt = el_inc;
          if (el_inc >= cfg.blink_half_ms) begin
            elapsed_nxt = '0;
            if (blinks_r != '0) begin
              phase_nxt  = !phase_r;
              led_nxt    = !phase_r ? LED_ACK : LED_NONE;
              blinks_nxt = blinks_r - TOG_W'(1);
            end else begin
              led_nxt   = LED_NONE;
              phase_nxt = 1'b0;
              mode_nxt  = DM_NONE;
            end
          end
        end
        default: ;  // nothing shown, tick has no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= DM_NONE;
      elapsed_r <= '0;
      blinks_r  <= '0;
      phase_r   <= 1'b0;
      led_r     <= LED_NONE;
    end else if (en) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      blinks_r  <= blinks_nxt;
      phase_r   <= phase_nxt;
      led_r     <= led_nxt;
    end
  end

  assign leds = led_nxt;
endmodule

[rtl/keypad_code_entry_with_led_feedback.sv]
// Keypad code entry with LED feedback.
//
// in_ch  : one transaction per keypad scan sample (op 0) or millisecond tick (op 1).
// out_ch : exactly one result transaction per input transaction, in order: LED
//          states, entry stage and stored count after the item, plus the stored
//          message (digits, letter, slot) on the item that completes "#DDL*".
// cfg_ch : register writes (0 short_show_ms, 1 blink_half_ms, 2 blink_toggles),
//          always ready; write only while the block is idle.
//
// An item taken from in_ch sits in the input register, is evaluated and lands
// in the result register when that is free, which drives out_ch.valid.
// Throughput: one item per cycle while out_ch does not stall, set by the single input
// and result register pair. A backpressured result holds in the result register; the
// input register keeps accepting until it too is full, then in_ch.ready drops
// the same cycle out_ch stalls (ready is combinational from out_ch.ready).
// Reset (rst_n low, synchronous): entry idle, no messages, LEDs off, registers back
// to 300 / 100 / 10, both pipeline registers empty.
module keypad_code_entry_with_led_feedback (
  input  logic      clk,
  input  logic      rst_n,
  kcled_in_if.sink  in_ch,
  kcled_out_if.source out_ch,
  kcled_cfg_if.sink cfg_ch
);
  import kcled_pkg::*;

  cfg_t             cfg;
  show_t            show;
  msg_t             msg;
  logic [LED_W-1:0] leds;

  // input register
  logic  s1_v_r;
  item_t s1_item_r;

  // result register
  logic             out_v_r;
  msg_t             out_msg_r;
  logic [LED_W-1:0] out_led_r;

  logic out_free;  // result register can take a new result this cycle
  logic adv;       // input register item is evaluated and retired this cycle
  logic in_take;

  assign out_free = !out_v_r || out_ch.ready;
  assign adv      = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{op: in_ch.op, key_down: in_ch.key_down, key_code: in_ch.key_code};
    end
  end

  kcled_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // key sequence checker; state moves only when an item retires
  kcled_entry u_entry (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (s1_item_r),
    .show  (show),
    .msg   (msg)
  );

  // LED timing: short indications and the blink run
  kcled_disp u_disp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .tick  (s1_item_r.op),
    .show  (show),
    .cfg   (cfg),
    .leds  (leds)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_msg_r <= msg;
      out_led_r <= leds;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.led_ack          = |(out_led_r & LED_ACK);
  assign out_ch.led_error        = |(out_led_r & LED_ERR);
  assign out_ch.led_full         = |(out_led_r & LED_FULL);
  assign out_ch.entry_stage      = out_msg_r.entry_stage;
  assign out_ch.stored_count     = out_msg_r.stored_count;
  assign out_ch.msg_done         = out_msg_r.msg_done;
  assign out_ch.msg_slot         = out_msg_r.msg_slot;
  assign out_ch.msg_first_digit  = out_msg_r.msg_first_digit;
  assign out_ch.msg_second_digit = out_msg_r.msg_second_digit;
  assign out_ch.msg_letter       = out_msg_r.msg_letter;
endmodule
